// File: sv/conv3x3_image_filter_top_macros.svh
// assertion macros for the 3x3 filter
`ifndef CONV3X3_IMAGE_FILTER_TOP_MACROS_SVH
`define CONV3X3_IMAGE_FILTER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define CONV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("conv3x3 check failed");

// next-cycle implication, checked during reset too
`define CONV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("conv3x3 check failed");

`endif

// File: sv/conv3x3_pkg.sv
`timescale 1ns / 1ps
package conv3x3_pkg;
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CHANNELS_DEF    = 3;

  localparam int FIELD_BITS    = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_MODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SAMPLE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_MODE   = 3'd4;

  localparam logic [1:0] KERNEL_LAPLACE = 2'd1;
  localparam logic [1:0] KERNEL_SHARPEN = 2'd2;

  localparam logic OP_DRAIN = 1'b1;

  localparam int ACC_BITS    = 22;
  localparam int SUM_BITS    = 20;
  localparam int RECIP_BITS  = 21;
  localparam int RECIP_SHIFT = 24;
  localparam int QUO_BITS    = 17;
  localparam logic [RECIP_BITS-1:0] RECIP_NINE = 21'd1864136;

  typedef struct packed {
    logic emit;
    logic top;
    logic bot;
    logic lft;
    logic rgt;
    logic last;
  } conv_flags_t;

  typedef struct packed {
    logic [1:0]            kernel_mode;
    logic [FIELD_BITS-1:0] max_sample;
    logic                  color_mode;
  } back_cfg_t;
endpackage

// File: sv/conv3x3_in_if.sv
`timescale 1ns / 1ps
interface conv3x3_in_if import conv3x3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [FIELD_BITS-1:0] sample_a;
  logic [FIELD_BITS-1:0] sample_b;
  logic [FIELD_BITS-1:0] sample_c;

  modport source(output valid, op, sample_a, sample_b, sample_c, input ready);
  modport sink(input valid, op, sample_a, sample_b, sample_c, output ready);
endinterface

// File: sv/conv3x3_out_if.sv
`timescale 1ns / 1ps
interface conv3x3_out_if import conv3x3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] result_a;
  logic [FIELD_BITS-1:0] result_b;
  logic [FIELD_BITS-1:0] result_c;
  logic                  frame_last;

  modport source(output valid, result_a, result_b, result_c, frame_last, input ready);
  modport sink(input valid, result_a, result_b, result_c, frame_last, output ready);
endinterface

// File: sv/conv3x3_image_filter_top.sv
// pipeline: a result passes the queue and the input, window, accumulator and output
// registers; results trail their pixels by one row plus one pixel of input words
// throughput: one word per cycle unless stalled, set by line store read-modify-write
// reset: synchronous active-low rst_n clears counters, queue, window and config
// registers to defaults; the line store is not cleared
`timescale 1ns / 1ps
`include "conv3x3_image_filter_top_macros.svh"
module conv3x3_image_filter_top import conv3x3_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CHANNELS    = CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  conv3x3_in_if.sink               in_s,
  conv3x3_out_if.source            out_s,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = CHANNELS * SAMPLE_BITS;
  localparam int FW = $bits(conv_flags_t);
  localparam int QW = FW + CW + LW;

  logic [1:0]  kernel_mode_r;
  logic [11:0] image_width_r;
  logic [15:0] image_height_r;
  logic [15:0] max_sample_r;
  logic        color_mode_r;

  logic          q_push, q_full, q_pop, q_empty;
  conv_flags_t   fr_flags, bk_flags;
  logic [CW-1:0] fr_col, bk_col;
  logic [LW-1:0] fr_px, bk_px;
  logic [QW-1:0] q_out;
  back_cfg_t     bcfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r  <= 2'd0;
      image_width_r  <= 12'd640;
      image_height_r <= 16'd480;
      max_sample_r   <= 16'd255;
      color_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_MODE:  kernel_mode_r  <= cfg_data[1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        CFG_MAX_SAMPLE:   max_sample_r   <= cfg_data;
        CFG_COLOR_MODE:   color_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign bcfg.kernel_mode = kernel_mode_r;
  assign bcfg.max_sample  = max_sample_r;
  assign bcfg.color_mode  = color_mode_r;

  conv3x3_front #(
    .MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS), .CHANNELS(CHANNELS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_s(in_s),
    .image_width(image_width_r), .image_height(image_height_r),
    .q_push(q_push), .q_flags(fr_flags), .q_col(fr_col), .q_px(fr_px), .q_full(q_full)
  );

  conv3x3_fifo #(.DW(QW), .DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data({fr_flags, fr_col, fr_px}), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  assign bk_flags = q_out[QW-1 -: FW];
  assign bk_col   = q_out[LW +: CW];
  assign bk_px    = q_out[LW-1:0];

  conv3x3_back #(
    .MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS), .CHANNELS(CHANNELS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_pop(q_pop), .q_empty(q_empty), .q_flags(bk_flags), .q_col(bk_col), .q_px(bk_px),
    .cfg(bcfg), .out_s(out_s)
  );

  `CONV_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty)
  `CONV_ASSERT_IMPL(a_full_stalls_input, q_full, !in_s.ready)
  `CONV_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_s.valid)
endmodule

// File: sv/conv3x3_fifo.sv
`timescale 1ns / 1ps
module conv3x3_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);
  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == (AW+1)'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

// File: sv/conv3x3_front.sv
`timescale 1ns / 1ps
module conv3x3_front import conv3x3_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int LW = CHANNELS * SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  conv3x3_in_if.sink  in_s,
  input  logic [11:0] image_width,
  input  logic [15:0] image_height,
  output logic        q_push,
  output conv_flags_t q_flags,
  output logic [CW-1:0] q_col,
  output logic [LW-1:0] q_px,
  input  logic        q_full
);
  logic [CW-1:0] wm1;
  logic [15:0]   hm1;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [16:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic          due, acc, drop;
  logic [FIELD_BITS-1:0] smp [3];

  always_comb begin
    if (image_width == '0) wm1 = '0;
    else if (32'(image_width) > MAX_WIDTH) wm1 = CW'(MAX_WIDTH - 1);
    else wm1 = CW'(image_width - 12'd1);
    hm1 = (image_height == '0) ? '0 : image_height - 16'd1;
  end

  assign in_s.ready = !q_full;
  assign acc    = in_s.valid && in_s.ready;
  assign due    = in_row_r <= {1'b0, hm1};
  assign drop   = (in_s.op == OP_DRAIN) && due;
  assign q_push = acc && !drop;
  assign q_col  = in_col_r;

  assign smp[0] = in_s.sample_a;
  assign smp[1] = in_s.sample_b;
  assign smp[2] = in_s.sample_c;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      q_px[c*SAMPLE_BITS +: SAMPLE_BITS] = due ? smp[c][SAMPLE_BITS-1:0] : '0;
    end
  end

  always_comb begin
    q_flags.emit = (in_row_r >= 17'd2) || (in_row_r == 17'd1 && in_col_r != '0);
    q_flags.top  = out_row_r != '0;
    q_flags.bot  = out_row_r < {1'b0, hm1};
    q_flags.lft  = out_col_r != '0;
    q_flags.rgt  = out_col_r < wm1;
    q_flags.last = (out_row_r >= {1'b0, hm1}) && (out_col_r >= wm1);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (q_push) begin
      if (in_col_r >= wm1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 17'd1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (q_flags.emit) begin
        if (q_flags.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_r >= wm1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 17'd1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end
endmodule

// File: sv/conv3x3_back.sv
`timescale 1ns / 1ps
module conv3x3_back import conv3x3_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int LW = CHANNELS * SAMPLE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          q_pop,
  input  logic          q_empty,
  input  conv_flags_t   q_flags,
  input  logic [CW-1:0] q_col,
  input  logic [LW-1:0] q_px,
  input  back_cfg_t     cfg,
  conv3x3_out_if.source out_s
);
  localparam int SB = SAMPLE_BITS;
  localparam int MW = 2 * LW;

  logic en;
  logic [MW-1:0] line_mem [MAX_WIDTH];
  logic v0_r, v1_r, v2_r, out_v_r, fwd_r;
  conv_flags_t f0_r, f1_r, f2_r;
  logic [CW-1:0] col0_r;
  logic [LW-1:0] px0_r;
  logic [MW-1:0] rd_r, fwd_d_r, rd_eff, wr_data;
  logic [3*LW-1:0] win_r [3];
  logic [SB-1:0] tap [3][3][CHANNELS];
  logic signed [ACC_BITS-1:0] acc_nxt [CHANNELS];
  logic signed [ACC_BITS-1:0] acc_r [CHANNELS];
  logic box_nxt, box_r, last_r;
  logic [FIELD_BITS-1:0] res_nxt [3];
  logic [FIELD_BITS-1:0] res_r [3];

  assign en     = !out_v_r || out_s.ready;
  assign q_pop  = en && !q_empty;
  assign rd_eff = fwd_r ? fwd_d_r : rd_r;
  // older line in the upper half, newer line in the lower half
  assign wr_data = {rd_eff[LW-1:0], px0_r};

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= line_mem[q_col];
      if (v0_r) line_mem[col0_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col0_r  <= q_col;
      px0_r   <= q_px;
      f0_r    <= q_flags;
      fwd_d_r <= wr_data;
      f1_r    <= f0_r;
      f2_r    <= f1_r;
      acc_r   <= acc_nxt;
      box_r   <= box_nxt;
      res_r   <= res_nxt;
      last_r  <= f2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
      fwd_r   <= 1'b0;
      win_r   <= '{default: '0};
    end else if (en) begin
      v0_r    <= q_pop;
      v1_r    <= v0_r && f0_r.emit;
      v2_r    <= v1_r;
      out_v_r <= v2_r;
      // same-address write in flight while the next read is issued
      fwd_r   <= v0_r && (col0_r == q_col);
      if (v0_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= {px0_r, rd_eff[LW-1:0], rd_eff[MW-1:LW]};
      end
    end
  end

  always_comb begin
    for (int cx = 0; cx < 3; cx++) begin
      for (int ry = 0; ry < 3; ry++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          tap[cx][ry][c] = win_r[cx][ry*LW + c*SB +: SB];
        end
      end
    end
  end

  always_comb begin
    logic signed [ACC_BITS-1:0] sum;
    logic signed [ACC_BITS-1:0] lap;
    logic signed [ACC_BITS-1:0] cen;
    box_nxt = !(cfg.kernel_mode == KERNEL_LAPLACE || cfg.kernel_mode == KERNEL_SHARPEN);
    for (int c = 0; c < CHANNELS; c++) begin
      sum = '0;
      for (int cx = 0; cx < 3; cx++) begin
        for (int ry = 0; ry < 3; ry++) begin
          if (!((cx == 0 && !f1_r.lft) || (cx == 2 && !f1_r.rgt) ||
                (ry == 0 && !f1_r.top) || (ry == 2 && !f1_r.bot))) begin
            sum = sum + $signed(ACC_BITS'(tap[cx][ry][c]));
          end
        end
      end
      cen = $signed(ACC_BITS'(tap[1][1][c]));
      lap = (cen <<< 2) + ((cfg.kernel_mode == KERNEL_SHARPEN) ? cen : '0);
      if (f1_r.top) lap = lap - $signed(ACC_BITS'(tap[1][0][c]));
      if (f1_r.bot) lap = lap - $signed(ACC_BITS'(tap[1][2][c]));
      if (f1_r.lft) lap = lap - $signed(ACC_BITS'(tap[0][1][c]));
      if (f1_r.rgt) lap = lap - $signed(ACC_BITS'(tap[2][1][c]));
      acc_nxt[c] = box_nxt ? sum : lap;
    end
  end

  always_comb begin
    logic [SUM_BITS+RECIP_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0] val;
    logic signed [ACC_BITS-1:0] lim;
    for (int c = 0; c < 3; c++) res_nxt[c] = '0;
    lim = $signed(ACC_BITS'(cfg.max_sample));
    for (int c = 0; c < CHANNELS; c++) begin
      // divide by nine through a reciprocal multiply
      prod = acc_r[c][SUM_BITS-1:0] * RECIP_NINE;
      val  = box_r ? $signed(ACC_BITS'(prod[RECIP_SHIFT +: QUO_BITS])) : acc_r[c];
      if (c == 0 || cfg.color_mode) begin
        if (val < 0) res_nxt[c] = '0;
        else if (val > lim) res_nxt[c] = cfg.max_sample;
        else res_nxt[c] = val[FIELD_BITS-1:0];
      end
    end
  end

  assign out_s.valid      = out_v_r;
  assign out_s.result_a   = res_r[0];
  assign out_s.result_b   = res_r[1];
  assign out_s.result_c   = res_r[2];
  assign out_s.frame_last = last_r;
endmodule
